>>> design/bpq_pkg.sv
// ----------------------------------------------------------------------------
// bpq_pkg
// Shared codes and controller/datapath interface types for the bucketed
// priority queue.
// ----------------------------------------------------------------------------
package bpq_pkg;

  // Operation codes on func
  localparam logic [1:0] FUNC_ENQ = 2'd0;
  localparam logic [1:0] FUNC_DEQ = 2'd1;
  localparam logic [1:0] FUNC_REM = 2'd2;
  localparam logic [1:0] FUNC_CLR = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_HIGH = 2'd2;

  localparam logic [5:0] MAX_LEVEL_RESET = 6'd63;

  // Datapath commands issued by the controller
  typedef struct packed {
    logic load;       // capture the incoming transaction
    logic take_head;  // capture the bucket head read for dequeue
    logic sel_cur;    // address bucket memories with the working level
    logic unlink;     // apply unlink writes
    logic append;     // apply append writes
    logic load_out;   // move the result into the output register
  } cmd_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic lvl_high;    // requested level above max_level or not below the level count
    logic id_out;      // entry_id beyond the pool
    logic id_queued;   // entry_id currently queued
    logic mask_empty;  // no bucket holds entries
    logic op_enq;      // captured operation is an enqueue
  } stat_t;

endpackage

>>> design/bpq_ram.sv
// ----------------------------------------------------------------------------
// bpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/bpq_ctrl.sv
// ----------------------------------------------------------------------------
// bpq_ctrl
// Operation sequencer: walks each transaction through the read, unlink and
// append steps and hands the result to the output register.
// ----------------------------------------------------------------------------
module bpq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      func,
  output logic            out_valid,
  input  logic            out_stall,
  input  bpq_pkg::stat_t  stat,
  output bpq_pkg::cmd_t   cmd
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_D_READ  = 9'b000000010,
    S_D_TAKE  = 9'b000000100,
    S_U_READ1 = 9'b000001000,
    S_U_READ2 = 9'b000010000,
    S_U_WRITE = 9'b000100000,
    S_A_READ  = 9'b001000000,
    S_A_WRITE = 9'b010000000,
    S_FINISH  = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   accept;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          unique case (func)
            bpq_pkg::FUNC_ENQ: begin
              if (stat.lvl_high || stat.id_out) begin
                state_next = S_FINISH;
              end else if (stat.id_queued) begin
                state_next = S_U_READ1;
              end else begin
                state_next = S_A_READ;
              end
            end
            bpq_pkg::FUNC_DEQ: begin
              state_next = stat.mask_empty ? S_FINISH : S_D_READ;
            end
            bpq_pkg::FUNC_REM: begin
              state_next = (stat.id_out || !stat.id_queued) ? S_FINISH : S_U_READ1;
            end
            default: begin
              state_next = S_FINISH;
            end
          endcase
        end
      end
      S_D_READ: begin
        cmd.sel_cur = 1'b1;
        state_next  = S_D_TAKE;
      end
      S_D_TAKE: begin
        cmd.sel_cur   = 1'b1;
        cmd.take_head = 1'b1;
        state_next    = S_U_READ1;
      end
      S_U_READ1: begin
        state_next = S_U_READ2;
      end
      S_U_READ2: begin
        state_next = S_U_WRITE;
      end
      S_U_WRITE: begin
        cmd.unlink = 1'b1;
        state_next = stat.op_enq ? S_A_READ : S_FINISH;
      end
      S_A_READ: begin
        cmd.sel_cur = 1'b1;
        state_next  = S_A_WRITE;
      end
      S_A_WRITE: begin
        cmd.sel_cur = 1'b1;
        cmd.append  = 1'b1;
        state_next  = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> design/bpq_dp.sv
// ----------------------------------------------------------------------------
// bpq_dp
// Queue datapath: bucket head/tail memories, link and level memories,
// non-empty mask, queued flags, config register and result registers.
// ----------------------------------------------------------------------------
module bpq_dp #(
  parameter int NUM_ENTRIES = 256,
  parameter int NUM_LEVELS  = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [5:0]      cfg_data,
  input  logic [1:0]      func,
  input  logic [7:0]      entry_id,
  input  logic [5:0]      priority_req,
  input  bpq_pkg::cmd_t   cmd,
  output bpq_pkg::stat_t  stat,
  output logic [1:0]      status,
  output logic [7:0]      out_entry,
  output logic [5:0]      out_level,
  output logic            table_empty
);

  localparam int EW = $clog2(NUM_ENTRIES);
  localparam int LW = $clog2(NUM_LEVELS);
  localparam int IW = (EW > 8) ? EW : 8;

  logic [5:0]             max_level;
  logic [NUM_LEVELS-1:0]  mask;
  logic [NUM_ENTRIES-1:0] queued;

  logic [1:0]    op;
  logic [EW-1:0] ent;
  logic [LW-1:0] cur_lvl;
  logic [1:0]    res_status;
  logic [7:0]    res_entry;
  logic [5:0]    res_level;

  logic [IW-1:0] id_wide;
  logic [EW-1:0] id_addr;
  logic [LW-1:0] top;
  logic [LW-1:0] req_lvl;
  logic [1:0]    load_status;

  logic [LW-1:0] level_rd;
  logic [EW-1:0] prev_rd, next_rd, first_rd, last_rd;
  logic [IW-1:0] head_wide;
  logic [LW-1:0] bkt_raddr, bkt_waddr;
  logic          is_first, is_last, bkt_busy;

  logic          first_we, last_we, next_we, prev_we, level_we;
  logic [EW-1:0] first_wd, last_wd, next_wa, next_wd, prev_wa, prev_wd;

  assign id_wide   = IW'(entry_id);
  assign id_addr   = id_wide[EW-1:0];
  assign req_lvl   = priority_req[LW-1:0];
  assign head_wide = IW'(first_rd);

  // Highest non-empty level
  always_comb begin
    top = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (mask[i]) begin
        top = LW'(i);
      end
    end
  end

  assign stat.lvl_high   = (priority_req > max_level) || (32'(priority_req) >= NUM_LEVELS);
  assign stat.id_out     = (32'(entry_id) >= NUM_ENTRIES);
  assign stat.id_queued  = queued[id_addr];
  assign stat.mask_empty = (mask == '0);
  assign stat.op_enq     = (op == bpq_pkg::FUNC_ENQ);

  always_comb begin
    load_status = bpq_pkg::ST_DONE;
    case (func)
      bpq_pkg::FUNC_ENQ: begin
        if (stat.lvl_high) begin
          load_status = bpq_pkg::ST_HIGH;
        end else if (stat.id_out) begin
          load_status = bpq_pkg::ST_MISS;
        end
      end
      bpq_pkg::FUNC_DEQ: begin
        if (stat.mask_empty) begin
          load_status = bpq_pkg::ST_MISS;
        end
      end
      bpq_pkg::FUNC_REM: begin
        if (stat.id_out || !stat.id_queued) begin
          load_status = bpq_pkg::ST_MISS;
        end
      end
      default: begin
        load_status = bpq_pkg::ST_DONE;
      end
    endcase
  end

  assign bkt_raddr = cmd.sel_cur ? cur_lvl : level_rd;
  assign is_first  = (first_rd == ent);
  assign is_last   = (last_rd == ent);
  assign bkt_busy  = mask[cur_lvl];

  // Memory write steering for unlink and append
  always_comb begin
    first_we  = 1'b0;
    last_we   = 1'b0;
    next_we   = 1'b0;
    prev_we   = 1'b0;
    level_we  = 1'b0;
    bkt_waddr = level_rd;
    first_wd  = next_rd;
    last_wd   = prev_rd;
    next_wa   = prev_rd;
    next_wd   = next_rd;
    prev_wa   = next_rd;
    prev_wd   = prev_rd;
    if (cmd.unlink) begin
      first_we = is_first && !is_last;
      last_we  = is_last && !is_first;
      next_we  = !is_first && !is_last;
      prev_we  = !is_first && !is_last;
    end else if (cmd.append) begin
      bkt_waddr = cur_lvl;
      level_we  = 1'b1;
      last_we   = 1'b1;
      last_wd   = ent;
      first_wd  = ent;
      first_we  = !bkt_busy;
      next_we   = bkt_busy;
      next_wa   = last_rd;
      next_wd   = ent;
      prev_we   = bkt_busy;
      prev_wa   = ent;
      prev_wd   = last_rd;
    end
  end

  bpq_ram #(.WIDTH(EW), .DEPTH(NUM_LEVELS)) u_first (
    .clk(clk), .we(first_we), .waddr(bkt_waddr), .wdata(first_wd),
    .raddr(bkt_raddr), .rdata(first_rd)
  );

  bpq_ram #(.WIDTH(EW), .DEPTH(NUM_LEVELS)) u_last (
    .clk(clk), .we(last_we), .waddr(bkt_waddr), .wdata(last_wd),
    .raddr(bkt_raddr), .rdata(last_rd)
  );

  bpq_ram #(.WIDTH(EW), .DEPTH(NUM_ENTRIES)) u_next (
    .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
    .raddr(ent), .rdata(next_rd)
  );

  bpq_ram #(.WIDTH(EW), .DEPTH(NUM_ENTRIES)) u_prev (
    .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
    .raddr(ent), .rdata(prev_rd)
  );

  bpq_ram #(.WIDTH(LW), .DEPTH(NUM_ENTRIES)) u_level (
    .clk(clk), .we(level_we), .waddr(ent), .wdata(cur_lvl),
    .raddr(ent), .rdata(level_rd)
  );

  // Control state: config, mask, queued flags
  always_ff @(posedge clk) begin
    if (rst) begin
      max_level <= bpq_pkg::MAX_LEVEL_RESET;
      mask      <= '0;
      queued    <= '0;
    end else begin
      if (cfg_we) begin
        max_level <= cfg_data;
      end
      if (cmd.load && (func == bpq_pkg::FUNC_CLR)) begin
        mask   <= '0;
        queued <= '0;
      end
      if (cmd.unlink) begin
        queued[ent] <= 1'b0;
        if (is_first && is_last) begin
          mask[level_rd] <= 1'b0;
        end
      end
      if (cmd.append) begin
        queued[ent]   <= 1'b1;
        mask[cur_lvl] <= 1'b1;
      end
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op         <= func;
      ent        <= id_addr;
      cur_lvl    <= (func == bpq_pkg::FUNC_DEQ) ? top : req_lvl;
      res_status <= load_status;
      res_entry  <= '0;
      res_level  <= '0;
    end
    if (cmd.take_head) begin
      ent       <= first_rd;
      res_entry <= head_wide[7:0];
      res_level <= 6'(cur_lvl);
    end
    if (cmd.load_out) begin
      status      <= res_status;
      out_entry   <= res_entry;
      out_level   <= res_level;
      table_empty <= (mask == '0);
    end
  end

endmodule

>>> design/bucketed_priority_queue_core.sv
// ----------------------------------------------------------------------------
// bucketed_priority_queue_core
// Clear and rejected requests go straight to the result; enqueue of an unqueued
// entry appends, dequeue reads the bucket head and unlinks it, requeue unlinks
// then appends, and remove unlinks. One transaction at a time; the next
// transaction is taken once the result is in the output register.
// Reset: synchronous; empties all buckets, max_level returns to 63.
// ----------------------------------------------------------------------------
module bucketed_priority_queue_core #(
  parameter int NUM_ENTRIES = 256,
  parameter int NUM_LEVELS  = 64
) (
  input  logic       clk,
  input  logic       rst,
  // configuration write channel (max_level)
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] cfg_data,
  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] func,
  input  logic [7:0] entry_id,
  input  logic [5:0] priority_req,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic [7:0] out_entry,
  output logic [5:0] out_level,
  output logic       table_empty
);

  // The single config register is always writable; writes are to arrive only while
  // the queue is idle, which the user must ensure: the block itself does not enforce it.
  assign cfg_ready = 1'b1;

  bpq_pkg::cmd_t  cmd;
  bpq_pkg::stat_t stat;

  // Sequencer: one transaction at a time through read, unlink and append
  // steps. Each memory step reads in its own state before using the registered read data.
  bpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: bucket and link memories plus the non-empty mask used to
  // find the highest level with waiting entries.
  bpq_dp #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .NUM_LEVELS  (NUM_LEVELS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .func         (func),
    .entry_id     (entry_id),
    .priority_req (priority_req),
    .cmd          (cmd),
    .stat         (stat),
    .status       (status),
    .out_entry    (out_entry),
    .out_level    (out_level),
    .table_empty  (table_empty)
  );

endmodule

>>> design/bpq_checker.sv
// ----------------------------------------------------------------------------
// bpq_checker
// Port-level checks on the priority queue result channel.
// ----------------------------------------------------------------------------
module bpq_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] status,
  input logic [7:0] out_entry,
  input logic [5:0] out_level
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_entry))
    else $error("stalled result changed");

  // Status code range.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == bpq_pkg::ST_DONE) || (status == bpq_pkg::ST_MISS) ||
                  (status == bpq_pkg::ST_HIGH))
    else $error("illegal status code");

  // Failed transactions carry no entry.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != bpq_pkg::ST_DONE) |-> (out_entry == 8'd0) && (out_level == 6'd0))
    else $error("failed transaction returned an entry");

  // Reset leaves an idle, empty output.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind bucketed_priority_queue_core bpq_checker u_bpq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .out_entry (out_entry),
  .out_level (out_level)
);
